// File: design/hm128_pkg.sv
// ----------------------------------------------------------------------------
// hm128_pkg
// Types, constants and code functions shared by the Hamming(12,8) byte
// stream codec modules.
// ----------------------------------------------------------------------------
package hm128_pkg;

   localparam int CW_POSITIONS = 12;
   localparam int BEATS_MAX    = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [1:0] PHASE_EMPTY = 2'd0;
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       corrected;
      logic       uncorrectable;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                count;
      rsp_type [BEATS_MAX-1:0]   beats;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // codeword in wire order: position 1 in bit 11
   function automatic logic [11:0] hm_encode(input logic [7:0] d);
      logic [12:1] pos;
      logic [11:0] w;
      pos     = '0;
      pos[3]  = d[0];
      pos[5]  = d[1];
      pos[6]  = d[2];
      pos[7]  = d[3];
      pos[9]  = d[4];
      pos[10] = d[5];
      pos[11] = d[6];
      pos[12] = d[7];
      pos[1]  = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
      pos[2]  = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
      pos[4]  = d[1] ^ d[2] ^ d[3] ^ d[7];
      pos[8]  = d[4] ^ d[5] ^ d[6] ^ d[7];
      for (int p = 1; p <= CW_POSITIONS; p++) begin
         w[CW_POSITIONS - p] = pos[p];
      end
      return w;
   endfunction

   function automatic rsp_type hm_decode(input logic [11:0] w);
      logic [12:1] pos;
      logic [3:0]  s;
      rsp_type     r;
      s = '0;
      r = '0;
      for (int p = 1; p <= CW_POSITIONS; p++) begin
         pos[p] = w[CW_POSITIONS - p];
      end
      for (int p = 1; p <= CW_POSITIONS; p++) begin
         if (pos[p]) begin
            s = s ^ 4'(p);
         end
      end
      if (s > 4'(CW_POSITIONS)) begin
         r.uncorrectable = 1'b1;
      end else begin
         if (s != 4'd0) begin
            pos[s]      = ~pos[s];
            r.corrected = 1'b1;
         end
         r.out_byte = {pos[12], pos[11], pos[10], pos[9], pos[7], pos[6], pos[5], pos[3]};
      end
      return r;
   endfunction

   function automatic rsp_type hm_byte(input logic [7:0] b);
      rsp_type r;
      r          = '0;
      r.out_byte = b;
      return r;
   endfunction

endpackage

// File: design/hm128_front.sv
// ----------------------------------------------------------------------------
// hm128_front
// Accepts stream bytes, tracks the group phase and held bits, and turns
// each byte into a job of zero to three result beats.
// ----------------------------------------------------------------------------
module hm128_front
   import hm128_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         accept,
   input  req_type      req,
   output logic         push,
   output job_type      push_job
);

   logic        mode_ff, mode_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic [11:0] cw;
   logic [23:0] enc_all;
   logic [15:0] dec_two;
   logic [23:0] dec_all;

   assign cw      = hm_encode(req.data_byte);
   assign enc_all = {held_ff[11:0], cw};
   assign dec_two = {held_ff[7:0], req.data_byte};
   assign dec_all = {held_ff, req.data_byte};

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      push     = 1'b0;
      push_job = '0;
      if (csr_wr_en) begin
         mode_in  = csr_wr_data;
         phase_in = PHASE_EMPTY;
         held_in  = '0;
      end else if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            if (phase_ff == PHASE_ONE) begin
               push              = 1'b1;
               push_job.count    = 2'd3;
               push_job.beats[0] = hm_byte(enc_all[23:16]);
               push_job.beats[1] = hm_byte(enc_all[15:8]);
               push_job.beats[2] = hm_byte(enc_all[7:0]);
               push_job.beats[2].run_last = 1'b1;
               phase_in          = PHASE_EMPTY;
               held_in           = '0;
            end else if (req.stream_end) begin
               push              = 1'b1;
               push_job.count    = 2'd2;
               push_job.beats[0] = hm_byte(cw[11:4]);
               push_job.beats[1] = hm_byte({cw[3:0], 4'b0000});
               push_job.beats[1].run_last = 1'b1;
               phase_in          = PHASE_EMPTY;
               held_in           = '0;
            end else begin
               held_in  = {4'b0000, cw};
               phase_in = PHASE_ONE;
            end
         end else begin
            if (phase_ff == PHASE_ONE) begin
               if (req.stream_end) begin
                  push              = 1'b1;
                  push_job.count    = 2'd1;
                  push_job.beats[0] = hm_decode(dec_two[15:4]);
                  push_job.beats[0].run_last = 1'b1;
                  phase_in          = PHASE_EMPTY;
                  held_in           = '0;
               end else begin
                  held_in  = dec_two;
                  phase_in = PHASE_TWO;
               end
            end else if (phase_ff == PHASE_TWO) begin
               push              = 1'b1;
               push_job.count    = 2'd2;
               push_job.beats[0] = hm_decode(dec_all[23:12]);
               push_job.beats[1] = hm_decode(dec_all[11:0]);
               push_job.beats[1].run_last = 1'b1;
               phase_in          = PHASE_EMPTY;
               held_in           = '0;
            end else if (req.stream_end) begin
               phase_in = PHASE_EMPTY;
               held_in  = '0;
            end else begin
               held_in  = {8'h00, req.data_byte};
               phase_in = PHASE_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         phase_ff <= PHASE_EMPTY;
         held_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// File: design/hm128_queue.sv
// ----------------------------------------------------------------------------
// hm128_queue
// Short job queue between the front and back parts of the codec.
// ----------------------------------------------------------------------------
module hm128_queue
   import hm128_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: design/hm128_back.sv
// ----------------------------------------------------------------------------
// hm128_back
// Walks the beats of the job at the queue head, one result beat per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module hm128_back
   import hm128_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      head,
   input  q_status_type status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       last_beat;

   assign rsp_valid = !status.empty;
   assign rsp       = head.beats[idx_ff];
   assign last_beat = (idx_ff == head.count - 2'd1);
   assign pop       = rsp_valid && !rsp_stall && last_beat;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && !rsp_stall) begin
         idx_in = last_beat ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: design/hamming_12_8_byte_stream_codec.sv
// ----------------------------------------------------------------------------
// hamming_12_8_byte_stream_codec
// Hamming(12,8) byte stream encoder and single-error-correcting decoder.
// ----------------------------------------------------------------------------
// The front takes one stream byte per cycle whenever the job queue has a free
// slot; the back emits one result byte per cycle from the queue head while
// rsp_stall is low. Encoding gives three bytes per two inputs, so a steady
// encode stream is limited by the single output beat per cycle; decoding
// gives two bytes per three inputs and is limited by the input rate. A byte
// that completes a group enters the queue in the cycle it is accepted and
// its first result can leave on the next cycle.
// Write mode (0 encode, 1 decode) only while the block is idle; a write drops
// any partial group.
module hamming_12_8_byte_stream_codec
   import hm128_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic         accept;
   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head;
   q_status_type q_status;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   hm128_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req),
      .push        (push),
      .push_job    (push_job)
   );

   hm128_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   hm128_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("job pushed into full queue");

   a_head_nonempty_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (head.count != 2'd0))
      else $error("queue head holds a job with no beats");

   a_job_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp.run_last) |=> rsp_valid)
      else $error("job ended before its last beat");

endmodule
